// File: rtl/vbop_pkg.sv
package vbop_pkg;

  localparam int SITES = 64;
  localparam int BONDS = 32;

  localparam int ACTION_W = 2;
  localparam int BOND_IDX_W = 5;
  localparam int SITE_W = 6;

  localparam int SITE_AW = $clog2(SITES);
  localparam int BOND_AW = $clog2(BONDS);
  localparam int SLOT_AW = BOND_AW + 1;
  localparam int SLOT_DEPTH = 2 * BONDS;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [BOND_AW-1:0] bond;
    logic               slot;
  } pos_t;

  localparam int POS_W = $bits(pos_t);

  typedef struct packed {
    logic              weight;
    logic [SITE_W-1:0] slot_zero_site;
    logic [SITE_W-1:0] slot_one_site;
  } res_t;

endpackage

// File: rtl/valence_bond_operator_apply_core.sv
// Channel   Handshake            Payload
// in        in_valid, in_stall   action, bond_index, first_site, second_site
// out       out_valid, out_stall weight, slot_zero_site, slot_one_site
//
// One request at a time through a sequencer over two one-read, one-write RAMs
// (bond slots and the site reverse map). Each request, unused actions included,
// ends with a hand-off to the output register; apply takes a shorter path
// when both sites share a bond.
// A result waits in the output register while the next request is taken.
// Reset clears control state only; no clearing pass runs over the RAMs.
module valence_bond_operator_apply_core
  import vbop_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACTION_W-1:0]   action,
  input  logic [BOND_IDX_W-1:0] bond_index,
  input  logic [SITE_W-1:0]     first_site,
  input  logic [SITE_W-1:0]     second_site,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  weight,
  output logic [SITE_W-1:0]     slot_zero_site,
  output logic [SITE_W-1:0]     slot_one_site
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD0, ST_LD1, ST_RD0, ST_RD1, ST_RD2,
    ST_AP0, ST_AP1, ST_AP2, ST_AP3, ST_AP4, ST_FIN
  } state_t;

  state_t                state;
  logic [BOND_IDX_W-1:0] bi;
  logic [SITE_W-1:0]     s0;
  logic [SITE_W-1:0]     s1;
  pos_t                  pa;
  res_t                  res;

  logic                  bond_we;
  logic [SLOT_AW-1:0]    bond_waddr;
  logic [SITE_W-1:0]     bond_wdata;
  logic [SLOT_AW-1:0]    bond_raddr;
  logic [SITE_W-1:0]     bond_rdata;
  logic                  pos_we;
  logic [SITE_AW-1:0]    pos_waddr;
  pos_t                  pos_wdata;
  logic [SITE_AW-1:0]    pos_raddr;
  pos_t                  pos_rdata;
  logic                  room;
  logic                  push;
  logic                  bi_ok;
  logic                  sites_ok;
  pos_t                  pa_other;

  function automatic logic site_ok(input logic [SITE_W-1:0] s);
    site_ok = int'(s) < SITES;
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign push = (state == ST_FIN);
  assign bi_ok = int'(bond_index) < BONDS;
  assign sites_ok = site_ok(first_site) && site_ok(second_site);
  assign pa_other = '{bond: pa.bond, slot: !pa.slot};

  always_comb begin
    bond_we = 1'b0;
    bond_waddr = {bi[BOND_AW-1:0], 1'b0};
    bond_wdata = s0;
    bond_raddr = {bi[BOND_AW-1:0], 1'b0};
    pos_we = 1'b0;
    pos_waddr = s0[SITE_AW-1:0];
    pos_wdata = '{bond: bi[BOND_AW-1:0], slot: 1'b0};
    pos_raddr = s0[SITE_AW-1:0];
    case (state)
      ST_LD0: begin
        bond_we = 1'b1;
        pos_we = site_ok(s0);
      end
      ST_LD1: begin
        bond_we = 1'b1;
        bond_waddr = {bi[BOND_AW-1:0], 1'b1};
        bond_wdata = s1;
        pos_we = site_ok(s1);
        pos_waddr = s1[SITE_AW-1:0];
        pos_wdata = '{bond: bi[BOND_AW-1:0], slot: 1'b1};
      end
      ST_RD1: begin
        bond_raddr = {bi[BOND_AW-1:0], 1'b1};
      end
      ST_AP1: begin
        pos_raddr = s1[SITE_AW-1:0];
      end
      ST_AP2: begin
        bond_raddr = pa_other;
      end
      ST_AP3: begin
        bond_we = 1'b1;
        bond_waddr = res.slot_one_site[SLOT_AW-1:0];
        bond_wdata = bond_rdata;
        pos_we = site_ok(bond_rdata);
        pos_waddr = bond_rdata[SITE_AW-1:0];
        pos_wdata = pos_t'(res.slot_one_site[SLOT_AW-1:0]);
      end
      ST_AP4: begin
        bond_we = 1'b1;
        bond_waddr = pa_other;
        bond_wdata = s1;
        pos_we = 1'b1;
        pos_waddr = s1[SITE_AW-1:0];
        pos_wdata = pa_other;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            bi <= bond_index;
            s0 <= first_site;
            s1 <= second_site;
            res <= '0;
            case (action_t'(action))
              ACT_LOAD:  state <= bi_ok ? ST_LD0 : ST_FIN;
              ACT_READ:  state <= bi_ok ? ST_RD0 : ST_FIN;
              ACT_APPLY: state <= sites_ok ? ST_AP0 : ST_FIN;
              default:   state <= ST_FIN;
            endcase
          end
        end
        ST_LD0: state <= ST_LD1;
        ST_LD1: state <= ST_FIN;
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          res.slot_zero_site <= bond_rdata;
          state <= ST_RD2;
        end
        ST_RD2: begin
          res.slot_one_site <= bond_rdata;
          state <= ST_FIN;
        end
        ST_AP0: state <= ST_AP1;
        ST_AP1: begin
          pa <= pos_rdata;
          state <= ST_AP2;
        end
        ST_AP2: begin
          // hold the second site's position in the result field for the swap in ST_AP3
          if (pos_rdata.bond == pa.bond) begin
            res.slot_one_site <= '0;
            state <= ST_FIN;
          end else begin
            res.slot_one_site <= SITE_W'(pos_rdata);
            state <= ST_AP3;
          end
        end
        ST_AP3: state <= ST_AP4;
        ST_AP4: begin
          res <= '{weight: 1'b1, slot_zero_site: '0, slot_one_site: '0};
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (room) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  vbop_ram #(.WIDTH(SITE_W), .DEPTH(SLOT_DEPTH)) u_bond_ram (
    .clk   (clk),
    .we    (bond_we),
    .waddr (bond_waddr),
    .wdata (bond_wdata),
    .raddr (bond_raddr),
    .rdata (bond_rdata)
  );

  vbop_ram #(.WIDTH(POS_W), .DEPTH(SITES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vbop_obuf u_obuf (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .res            (res),
    .room           (room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .weight         (weight),
    .slot_zero_site (slot_zero_site),
    .slot_one_site  (slot_one_site)
  );

endmodule

// File: rtl/vbop_ram.sv
module vbop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/vbop_obuf.sv
module vbop_obuf
  import vbop_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_t              res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              weight,
  output logic [SITE_W-1:0] slot_zero_site,
  output logic [SITE_W-1:0] slot_one_site
);

  res_t held;

  assign room = !out_valid || !out_stall;
  assign weight = held.weight;
  assign slot_zero_site = held.slot_zero_site;
  assign slot_one_site = held.slot_one_site;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push && room) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && room) begin
      held <= res;
    end
  end

endmodule
